// ===== rtl/core/line_closest_approach_3d_macros.svh =====
// Assertion macros for the line closest approach block.
// Included by modules that carry concurrent checks; needs nothing else.
`ifndef LINE_CLOSEST_APPROACH_3D_MACROS_SVH
`define LINE_CLOSEST_APPROACH_3D_MACROS_SVH
`ifndef ASSERT_OFF
// Check that is switched off while reset is active.
`define LCA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that also runs during reset.
`define LCA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define LCA_ASSERT(label, clk, rst_n, prop, msg)
`define LCA_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== rtl/core/lca_pkg.sv =====
// Types, constants and the divider step for the line closest approach block.
// Has no dependencies.
package lca_pkg;

    // Cosine of one in Q.17 and its square in Q.34.
    localparam int COS_ONE = 131072;
    localparam logic [34:0] COS_ONE_SQ = 35'h4_0000_0000;
    // Smallest denominator a non-parallel pair can produce.
    localparam logic [34:0] DEN_MIN = 35'd262143;
    // Quotient bits of the distance divider.
    localparam int DIV_BITS = 46;

    // Values that ride along the pipeline for the midpoint.
    typedef struct packed {
        logic [2:0][24:0] ab;
        logic [2:0][15:0] u;
        logic [2:0][15:0] v;
        logic             par;
    } side_t;

    // One restoring division step: returns the quotient bit over the new remainder.
    function automatic logic [35:0] div_step(logic [34:0] rem, logic nbit, logic [34:0] den);
        logic [35:0] trial;
        logic [35:0] diff;
        trial = {rem, nbit};
        diff  = trial - {1'b0, den};
        if (!diff[35]) begin
            return {1'b1, diff[34:0]};
        end
        return {1'b0, trial[34:0]};
    endfunction

endpackage

// ===== rtl/core/line_closest_approach_3d.sv =====
// Closest approach of two 3D lines, fully pipelined.
// Depends on lca_pkg and line_closest_approach_3d_macros.svh.
//
// Takes one request per cycle, each holding two lines as point and unit
// direction, and returns the distances along each line to the points of
// closest approach and their midpoint, or parallel_error with zeroed data
// when the lines are too close to parallel. The pipeline has nine stages
// for the dot products, cosine and numerators, one stage per quotient bit
// of the two 46-bit restoring dividers, and six stages for the midpoint,
// rounding and saturation. Throughput is one request per cycle; the whole
// pipeline holds while a finished result is not taken. The user must write
// the parallel_limit register through cfg_valid and cfg_data only while no
// request is in flight; the block itself does not enforce this. It resets to 1.
`include "line_closest_approach_3d_macros.svh"

module line_closest_approach_3d (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [14:0]  cfg_data,     // parallel_limit
    input  logic         s_tvalid,
    output logic         s_tready,
    // first_x, first_y, first_z, first_dx, first_dy, first_dz,
    // second_x, second_y, second_z, second_dx, second_dy, second_dz
    input  logic [239:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // meet_x, meet_y, meet_z, first_distance, second_distance
    output logic [135:0] m_tdata,
    output logic         m_tuser       // parallel_error
);

    localparam int NB = lca_pkg::DIV_BITS;

    logic        en;
    logic [14:0] limit_reg;

    // Configuration register.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= 15'd1;
        end else if (cfg_valid) begin
            limit_reg <= cfg_data;
        end
    end

    // The pipeline advances unless a result waits at the output.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Stage registers.
    logic                v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg, v9_reg;
    lca_pkg::side_t      side1_reg, side2_reg, side3_reg, side4_reg, side5_reg;
    lca_pkg::side_t      side6_reg, side7_reg, side8_reg, side9_reg;
    logic signed [24:0]  d1_reg [3];
    logic signed [31:0]  uv2_reg [3];
    logic signed [40:0]  ud2_reg [3];
    logic signed [40:0]  vd2_reg [3];
    logic signed [33:0]  craw3_reg;
    logic signed [42:0]  du3_reg, du4_reg, du5_reg, dv3_reg, dv4_reg, dv5_reg;
    logic [31:0]         cmag4_reg;
    logic                csign4_reg, csign5_reg, csign6_reg;
    logic [21:0]         cabs5_reg;
    logic [33:0]         cc6_reg;
    logic signed [60:0]  cdv6_reg, cdu6_reg;
    logic signed [42:0]  du6_reg, dv6_reg;
    logic [34:0]         den7_reg, den8_reg, den9_reg;
    logic signed [61:0]  np7_reg, nq7_reg;
    logic [63:0]         pm8_reg, qm8_reg, pn9_reg, qn9_reg;
    logic                ps8_reg, qs8_reg, ps9_reg, qs9_reg;

    // Divider stage registers.
    logic                dvld_reg [NB];
    lca_pkg::side_t      dside_reg [NB];
    logic [34:0]         dden_reg [NB];
    logic [63:0]         dnp_reg [NB];
    logic [63:0]         dnq_reg [NB];
    logic [34:0]         dremp_reg [NB];
    logic [34:0]         dremq_reg [NB];
    logic [NB-1:0]       dqp_reg [NB];
    logic [NB-1:0]       dqq_reg [NB];
    logic                dsp_reg [NB];
    logic                dsq_reg [NB];

    // Post-divider stage registers.
    logic                va_reg, vb_reg, vc_reg, vd_reg, ve_reg;
    logic                para_reg, parb_reg, parc_reg, pard_reg, pare_reg;
    logic [2:0][15:0]    ua_reg, va_dir_reg;
    logic [2:0][24:0]    aba_reg;
    logic signed [NB:0]  pa_reg, qa_reg, pb_reg, qb_reg, pc_reg, qc_reg;
    logic signed [NB:0]  pd_reg, qd_reg, pe_reg, qe_reg;
    logic signed [62:0]  upb_reg [3];
    logic signed [62:0]  vqb_reg [3];
    logic signed [38:0]  abb_reg [3];
    logic signed [64:0]  sc_reg [3];
    logic [63:0]         smd_reg [3];
    logic                ssd_reg [3];
    logic                sse_reg [3];
    logic [49:0]         re_reg [3];

    logic         m_tvalid_reg;
    logic [135:0] m_tdata_reg;
    logic         m_tuser_reg;

    // Input field slices.
    logic signed [23:0] in_a [3];
    logic signed [23:0] in_b [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_a[i] = $signed(s_tdata[24*i +: 24]);
            in_b[i] = $signed(s_tdata[120 + 24*i +: 24]);
        end
    end

    // Valid bits of every stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0; v4_reg <= 1'b0; v5_reg <= 1'b0;
            v6_reg <= 1'b0; v7_reg <= 1'b0; v8_reg <= 1'b0; v9_reg <= 1'b0;
            for (int k = 0; k < NB; k++) begin
                dvld_reg[k] <= 1'b0;
            end
            va_reg <= 1'b0; vb_reg <= 1'b0; vc_reg <= 1'b0; vd_reg <= 1'b0; ve_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid; v2_reg <= v1_reg; v3_reg <= v2_reg; v4_reg <= v3_reg;
            v5_reg <= v4_reg; v6_reg <= v5_reg; v7_reg <= v6_reg; v8_reg <= v7_reg;
            v9_reg <= v8_reg;
            for (int k = 0; k < NB; k++) begin
                dvld_reg[k] <= (k == 0) ? v9_reg : dvld_reg[(k == 0) ? 0 : k - 1];
            end
            va_reg <= dvld_reg[NB-1]; vb_reg <= va_reg; vc_reg <= vb_reg;
            vd_reg <= vc_reg; ve_reg <= vd_reg;
            m_tvalid_reg <= ve_reg;
        end
    end

    // Stages one to three: differences, products and dot products.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                d1_reg[i]       <= 25'(in_b[i]) - 25'(in_a[i]);
                side1_reg.ab[i] <= 25'(in_b[i]) + 25'(in_a[i]);
                side1_reg.u[i]  <= s_tdata[72 + 16*i +: 16];
                side1_reg.v[i]  <= s_tdata[192 + 16*i +: 16];
                uv2_reg[i] <= $signed(side1_reg.u[i]) * $signed(side1_reg.v[i]);
                ud2_reg[i] <= $signed(side1_reg.u[i]) * d1_reg[i];
                vd2_reg[i] <= $signed(side1_reg.v[i]) * d1_reg[i];
            end
            side1_reg.par <= 1'b0;
            side2_reg <= side1_reg;
            craw3_reg <= 34'(uv2_reg[0]) + 34'(uv2_reg[1]) + 34'(uv2_reg[2]);
            du3_reg   <= 43'(ud2_reg[0]) + 43'(ud2_reg[1]) + 43'(ud2_reg[2]);
            dv3_reg   <= 43'(vd2_reg[0]) + 43'(vd2_reg[1]) + 43'(vd2_reg[2]);
            side3_reg <= side2_reg;
        end
    end

    // Stages four to six: rounded cosine, parallel test and cosine products.
    logic [16:0] cabs17;
    logic [17:0] cgap;
    logic        cbig;
    assign cabs17 = cabs5_reg[16:0];
    assign cbig   = |cabs5_reg[21:17];
    assign cgap   = 18'(lca_pkg::COS_ONE) - {1'b0, cabs17};

    always_ff @(posedge aclk) begin
        if (en) begin
            cmag4_reg  <= craw3_reg[33] ? 32'(-craw3_reg) : 32'(craw3_reg);
            csign4_reg <= craw3_reg[33];
            du4_reg    <= du3_reg;
            dv4_reg    <= dv3_reg;
            side4_reg  <= side3_reg;

            cabs5_reg  <= 22'(({1'b0, cmag4_reg} + 33'd1024) >> 11);
            csign5_reg <= csign4_reg;
            du5_reg    <= du4_reg;
            dv5_reg    <= dv4_reg;
            side5_reg  <= side4_reg;

            cc6_reg    <= cabs17 * cabs17;
            cdv6_reg   <= $signed({1'b0, cabs17}) * dv5_reg;
            cdu6_reg   <= $signed({1'b0, cabs17}) * du5_reg;
            csign6_reg <= csign5_reg;
            du6_reg    <= du5_reg;
            dv6_reg    <= dv5_reg;
            side6_reg  <= {side5_reg.ab, side5_reg.u, side5_reg.v,
                           cbig || (cgap < {limit_reg, 3'b000})};
        end
    end

    // Stages seven to nine: denominator, numerators, magnitudes with rounding offset.
    logic signed [61:0] dush, dvsh, cdu_s;
    assign dush  = 62'($signed({du6_reg, 17'b0}));
    assign dvsh  = 62'($signed({dv6_reg, 17'b0}));
    assign cdu_s = csign6_reg ? -62'(cdu6_reg) : 62'(cdu6_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            den7_reg  <= lca_pkg::COS_ONE_SQ - {1'b0, cc6_reg};
            np7_reg   <= csign6_reg ? (dush + 62'(cdv6_reg)) : (dush - 62'(cdv6_reg));
            nq7_reg   <= cdu_s - dvsh;
            side7_reg <= side6_reg;

            pm8_reg   <= {1'b0, 60'(np7_reg[61] ? -np7_reg : np7_reg), 3'b000};
            qm8_reg   <= {1'b0, 60'(nq7_reg[61] ? -nq7_reg : nq7_reg), 3'b000};
            ps8_reg   <= np7_reg[61];
            qs8_reg   <= nq7_reg[61];
            den8_reg  <= den7_reg;
            side8_reg <= side7_reg;

            pn9_reg   <= pm8_reg + 64'(den8_reg >> 1);
            qn9_reg   <= qm8_reg + 64'(den8_reg >> 1);
            ps9_reg   <= ps8_reg;
            qs9_reg   <= qs8_reg;
            den9_reg  <= den8_reg;
            side9_reg <= side8_reg;
        end
    end

    // Restoring dividers, one quotient bit per stage for P and Q.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NB; k++) begin
                logic [34:0]   remp, remq, den;
                logic [63:0]   np, nq;
                logic [NB-1:0] qp, qq;
                logic [35:0]   rp, rq;
                if (k == 0) begin
                    remp = 35'(pn9_reg[63:NB]);
                    remq = 35'(qn9_reg[63:NB]);
                    den  = den9_reg;
                    np   = pn9_reg;
                    nq   = qn9_reg;
                    qp   = '0;
                    qq   = '0;
                end else begin
                    remp = dremp_reg[k-1];
                    remq = dremq_reg[k-1];
                    den  = dden_reg[k-1];
                    np   = dnp_reg[k-1];
                    nq   = dnq_reg[k-1];
                    qp   = dqp_reg[k-1];
                    qq   = dqq_reg[k-1];
                end
                rp = lca_pkg::div_step(remp, np[NB-1-k], den);
                rq = lca_pkg::div_step(remq, nq[NB-1-k], den);
                dremp_reg[k] <= rp[34:0];
                dremq_reg[k] <= rq[34:0];
                dqp_reg[k]   <= {qp[NB-2:0], rp[35]};
                dqq_reg[k]   <= {qq[NB-2:0], rq[35]};
                dden_reg[k]  <= den;
                dnp_reg[k]   <= np;
                dnq_reg[k]   <= nq;
                dsp_reg[k]   <= (k == 0) ? ps9_reg : dsp_reg[(k == 0) ? 0 : k - 1];
                dsq_reg[k]   <= (k == 0) ? qs9_reg : dsq_reg[(k == 0) ? 0 : k - 1];
                dside_reg[k] <= (k == 0) ? side9_reg : dside_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    // Post stages: signed distances, midpoint sums, rounding.
    logic signed [NB:0] qp_pos, qq_pos;
    assign qp_pos = $signed({1'b0, dqp_reg[NB-1]});
    assign qq_pos = $signed({1'b0, dqq_reg[NB-1]});

    always_ff @(posedge aclk) begin
        if (en) begin
            pa_reg     <= dsp_reg[NB-1] ? -qp_pos : qp_pos;
            qa_reg     <= dsq_reg[NB-1] ? -qq_pos : qq_pos;
            para_reg   <= dside_reg[NB-1].par;
            ua_reg     <= dside_reg[NB-1].u;
            va_dir_reg <= dside_reg[NB-1].v;
            aba_reg    <= dside_reg[NB-1].ab;

            for (int i = 0; i < 3; i++) begin
                upb_reg[i] <= $signed(ua_reg[i]) * pa_reg;
                vqb_reg[i] <= $signed(va_dir_reg[i]) * qa_reg;
                abb_reg[i] <= $signed({aba_reg[i], 14'b0});
                sc_reg[i]  <= 65'(abb_reg[i]) + 65'(upb_reg[i]) + 65'(vqb_reg[i]);
                smd_reg[i] <= sc_reg[i][64] ? 64'(-sc_reg[i]) : 64'(sc_reg[i]);
                ssd_reg[i] <= sc_reg[i][64];
                re_reg[i]  <= 50'((65'(smd_reg[i]) + 65'd16384) >> 15);
                sse_reg[i] <= ssd_reg[i];
            end
            pb_reg <= pa_reg; qb_reg <= qa_reg; parb_reg <= para_reg;
            pc_reg <= pb_reg; qc_reg <= qb_reg; parc_reg <= parb_reg;
            pd_reg <= pc_reg; qd_reg <= qc_reg; pard_reg <= parc_reg;
            pe_reg <= pd_reg; qe_reg <= qd_reg; pare_reg <= pard_reg;
        end
    end

    // Output stage: saturation and zeroing of parallel results.
    logic [135:0]       out_next;
    logic signed [50:0] mval;
    always_comb begin
        out_next = '0;
        mval     = '0;
        for (int i = 0; i < 3; i++) begin
            mval = sse_reg[i] ? -$signed({1'b0, re_reg[i]}) : $signed({1'b0, re_reg[i]});
            if (mval > 51'sd8388607) begin
                out_next[24*i +: 24] = 24'h7F_FFFF;
            end else if (mval < -51'sd8388608) begin
                out_next[24*i +: 24] = 24'h80_0000;
            end else begin
                out_next[24*i +: 24] = mval[23:0];
            end
        end
        if (pe_reg > 47'sd2147483647) begin
            out_next[103:72] = 32'h7FFF_FFFF;
        end else if (pe_reg < -47'sd2147483648) begin
            out_next[103:72] = 32'h8000_0000;
        end else begin
            out_next[103:72] = pe_reg[31:0];
        end
        if (qe_reg > 47'sd2147483647) begin
            out_next[135:104] = 32'h7FFF_FFFF;
        end else if (qe_reg < -47'sd2147483648) begin
            out_next[135:104] = 32'h8000_0000;
        end else begin
            out_next[135:104] = qe_reg[31:0];
        end
        if (pare_reg) begin
            out_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= out_next;
            m_tuser_reg <= pare_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Checks.
    `LCA_ASSERT(a_par_zero, aclk, aresetn, (m_tvalid && m_tuser) |-> (m_tdata == '0), "parallel result carries data")
    `LCA_ASSERT(a_den_min, aclk, aresetn, (dvld_reg[0] && !dside_reg[0].par) |-> (dden_reg[0] >= lca_pkg::DEN_MIN), "divider denominator too small")
    `LCA_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid, "result valid right after reset")

endmodule
